// ----- sv/multi_servo_pose_interpolator_assert.svh -----
// Assertion macros used by the pose interpolator checker.
`ifndef MULTI_SERVO_POSE_INTERPOLATOR_ASSERT_SVH
`define MULTI_SERVO_POSE_INTERPOLATOR_ASSERT_SVH

// General property, clocked on clk and disabled in reset.
`define MSPI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// A stalled transaction keeps the given signal stable.
`define MSPI_ASSERT_HOLD(label, vld, rdy, sig, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (vld && !rdy) |=> $stable(sig)) \
    else $error(msg);

`endif

// ----- sv/mspi_pkg.sv -----
// Shared types and constants of the pose interpolator.
`default_nettype none

package mspi_pkg;

  localparam int OP_W   = 3;
  localparam int IDX_W  = 5;
  localparam int ID_W   = 8;
  localparam int POS_W  = 10;
  localparam int DUR_W  = 16;
  localparam int CNT_W  = 6;

  localparam int COUNT_RESET = 32;
  localparam int MID_POS     = 512;

  // Shared divider: 16-bit dividend, 17-bit divisor, one quotient bit a cycle.
  localparam int DIV_NW = 16;
  localparam int DIV_DW = 17;
  localparam int DIV_CW = 4;

  localparam logic [OP_W-1:0] OP_SET_ID      = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_TARGET  = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_CURRENT = 3'd2;
  localparam logic [OP_W-1:0] OP_START       = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK        = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRAMES,
    ST_STEP_RD,
    ST_STEP_GO,
    ST_STEP_WAIT,
    ST_TICK_RD,
    ST_TICK_UPD,
    ST_EMIT_RD,
    ST_EMIT_LOAD
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- sv/mspi_div.sv -----
// Iterative restoring divider shared by the frame count and the step sizes.
`default_nettype none

module mspi_div (
  input  logic               clk,
  input  logic               rst,
  input  mspi_pkg::div_req_t req,
  output mspi_pkg::div_rsp_t rsp
);

  logic [mspi_pkg::DIV_DW-1:0] rem;
  logic [mspi_pkg::DIV_NW-1:0] quo;
  logic [mspi_pkg::DIV_DW-1:0] dsr;
  logic [mspi_pkg::DIV_CW-1:0] cnt;
  logic                        busy;
  logic                        done;
  logic [mspi_pkg::DIV_DW:0]   sh;
  logic                        fit;

  // Bring down the next dividend bit and try the divisor.
  assign sh  = {rem, quo[mspi_pkg::DIV_NW-1]};
  assign fit = sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == mspi_pkg::DIV_CW'(mspi_pkg::DIV_NW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
      cnt <= '0;
    end else if (busy) begin
      rem <= fit ? mspi_pkg::DIV_DW'(sh - {1'b0, dsr}) : sh[mspi_pkg::DIV_DW-1:0];
      quo <= {quo[mspi_pkg::DIV_NW-2:0], fit};
      cnt <= cnt + mspi_pkg::DIV_CW'(1);
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// ----- sv/mspi_store.sv -----
// Per-slot store: one write port, one registered read port, reset value until written.
`default_nettype none

module mspi_store #(
  parameter int               DEPTH         = 32,
  parameter int               AW            = 5,
  parameter int               WIDTH         = 8,
  parameter bit               INIT_BY_INDEX = 1'b0,
  parameter logic [WIDTH-1:0] INIT_VALUE    = '0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] mem_q;
  logic             vld_q;
  logic [AW-1:0]    raddr_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q   <= mem[raddr];
    raddr_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      vld_q <= vld[raddr];
    end
  end

  // An entry never written reads as its reset value.
  assign rdata = vld_q ? mem_q
               : (INIT_BY_INDEX ? WIDTH'(raddr_q) + WIDTH'(1) : INIT_VALUE);

endmodule

`default_nettype wire

// ----- sv/multi_servo_pose_interpolator.sv -----
// Top level of the multi-servo pose interpolator: sequencer, slot stores and divider.
// Usage:
//   in channel (in_valid/in_ready) takes one command per transaction: set id, set
//   target, set current, start move or frame tick. cfg channel (cfg_valid/cfg_ready,
//   cfg_data) writes servo_count and is always ready; write it only while idle.
//   out channel (out_valid/out_ready) carries one transaction per servo in use on
//   each tick of an active move, in slot order, last flagging the highest slot.
// Sequencing:
//   Set commands, and a tick while no move is active, finish without leaving idle.
//   A start runs the shared 16-step divider once for the frame count and once per
//   servo in use, storing each step size.
//   A tick walks the slots twice, with one read address for all stores: first to
//   update each slot, then to emit one result per slot while the receiver keeps up.
//   in_ready is low while a command is being worked on; the last result of a tick
//   may still wait in the output register while the next command is taken.
// Reset clears the sequencer, move flag and output valid, sets servo_count to 32;
// the slot stores read their reset values through per-entry valid flags at once.
// A stalled receiver holds the current result and pauses the tick sequence.
`default_nettype none

module multi_servo_pose_interpolator #(
  parameter int MAX_SERVOS    = 32,
  parameter int FRACTION_BITS = 3,
  parameter int FRAME_MS      = 33
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mspi_pkg::OP_W-1:0]    operation,
  input  logic [mspi_pkg::IDX_W-1:0]   servo_index,
  input  logic [mspi_pkg::ID_W-1:0]    servo_id,
  input  logic [mspi_pkg::POS_W-1:0]   position,
  input  logic [mspi_pkg::DUR_W-1:0]   duration_ms,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mspi_pkg::CNT_W-1:0]   cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mspi_pkg::ID_W-1:0]    out_servo_id,
  output logic [mspi_pkg::POS_W-1:0]   out_position,
  output logic                         last,
  output logic                         moving
);

  localparam int PW = mspi_pkg::POS_W + FRACTION_BITS;
  localparam int SW = PW + 1;
  localparam int AW = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;
  localparam int CW = mspi_pkg::CNT_W;
  localparam logic [PW-1:0] POSE_RESET = PW'(mspi_pkg::MID_POS) << FRACTION_BITS;

  mspi_pkg::state_t state, state_next;

  logic [CW-1:0] servo_count;
  logic [CW-1:0] n_use;
  logic [CW-1:0] slot, slot_next;
  logic [mspi_pkg::DIV_DW-1:0] frames, frames_next;
  logic all_arr, all_arr_next;
  logic move_active, move_active_next;

  logic accept;
  logic in_range;
  logic last_slot;
  logic ld;

  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic id_we, tgt_we, cur_we, stp_we;
  logic [PW-1:0] pos_fix;
  logic [PW-1:0] cur_wdata;
  logic [SW-1:0] stp_wdata;

  logic [mspi_pkg::ID_W-1:0] id_rd;
  logic [PW-1:0] cur_rd, tgt_rd;
  logic [SW-1:0] stp_rd;

  logic tgt_gt;
  logic [PW-1:0] diff;
  logic arr_i;
  logic [PW-1:0] new_cur;

  mspi_pkg::div_req_t div_req;
  mspi_pkg::div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == mspi_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_range  = int'(servo_index) < MAX_SERVOS;
  assign n_use     = (int'(servo_count) > MAX_SERVOS) ? CW'(MAX_SERVOS) : servo_count;
  assign last_slot = (slot == n_use - CW'(1));
  assign raddr     = slot[AW-1:0];
  assign pos_fix   = PW'(position) << FRACTION_BITS;

  // Move one servo toward its target, snapping when closer than a step.
  assign tgt_gt  = tgt_rd > cur_rd;
  assign diff    = tgt_gt ? tgt_rd - cur_rd : cur_rd - tgt_rd;
  assign arr_i   = (cur_rd == tgt_rd) || (SW'(diff) < stp_rd);
  assign new_cur = arr_i  ? tgt_rd
                 : tgt_gt ? cur_rd + PW'(stp_rd)
                 :          cur_rd - PW'(stp_rd);

  mspi_store #(
    .DEPTH(MAX_SERVOS), .AW(AW), .WIDTH(mspi_pkg::ID_W),
    .INIT_BY_INDEX(1'b1), .INIT_VALUE('0)
  ) u_ids (
    .clk(clk), .rst(rst), .we(id_we), .waddr(waddr), .wdata(servo_id),
    .raddr(raddr), .rdata(id_rd)
  );

  mspi_store #(
    .DEPTH(MAX_SERVOS), .AW(AW), .WIDTH(PW),
    .INIT_BY_INDEX(1'b0), .INIT_VALUE(POSE_RESET)
  ) u_cur (
    .clk(clk), .rst(rst), .we(cur_we), .waddr(waddr), .wdata(cur_wdata),
    .raddr(raddr), .rdata(cur_rd)
  );

  mspi_store #(
    .DEPTH(MAX_SERVOS), .AW(AW), .WIDTH(PW),
    .INIT_BY_INDEX(1'b0), .INIT_VALUE(POSE_RESET)
  ) u_tgt (
    .clk(clk), .rst(rst), .we(tgt_we), .waddr(waddr), .wdata(pos_fix),
    .raddr(raddr), .rdata(tgt_rd)
  );

  mspi_store #(
    .DEPTH(MAX_SERVOS), .AW(AW), .WIDTH(SW),
    .INIT_BY_INDEX(1'b0), .INIT_VALUE('0)
  ) u_stp (
    .clk(clk), .rst(rst), .we(stp_we), .waddr(waddr), .wdata(stp_wdata),
    .raddr(raddr), .rdata(stp_rd)
  );

  mspi_div u_div (
    .clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= mspi_pkg::ST_IDLE;
      move_active <= 1'b0;
      servo_count <= CW'(mspi_pkg::COUNT_RESET);
    end else begin
      state       <= state_next;
      move_active <= move_active_next;
      if (cfg_valid && cfg_ready) begin
        servo_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot    <= slot_next;
    frames  <= frames_next;
    all_arr <= all_arr_next;
  end

  always_comb begin
    state_next       = state;
    slot_next        = slot;
    frames_next      = frames;
    all_arr_next     = all_arr;
    move_active_next = move_active;
    id_we            = 1'b0;
    tgt_we           = 1'b0;
    cur_we           = 1'b0;
    stp_we           = 1'b0;
    waddr            = raddr;
    cur_wdata        = pos_fix;
    stp_wdata        = SW'(div_rsp.quotient) + SW'(1);
    ld               = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = mspi_pkg::DIV_NW'(diff);
    div_req.divisor  = frames;

    case (state)
      mspi_pkg::ST_IDLE: begin
        if (accept) begin
          case (operation)
            mspi_pkg::OP_SET_ID: begin
              waddr = AW'(servo_index);
              id_we = in_range;
            end
            mspi_pkg::OP_SET_TARGET: begin
              waddr  = AW'(servo_index);
              tgt_we = in_range;
            end
            mspi_pkg::OP_SET_CURRENT: begin
              waddr  = AW'(servo_index);
              cur_we = in_range;
            end
            mspi_pkg::OP_START: begin
              div_req.start    = 1'b1;
              div_req.dividend = duration_ms;
              div_req.divisor  = mspi_pkg::DIV_DW'(FRAME_MS);
              state_next       = mspi_pkg::ST_FRAMES;
            end
            mspi_pkg::OP_TICK: begin
              if (move_active) begin
                if (n_use == '0) begin
                  move_active_next = 1'b0;
                end else begin
                  slot_next    = '0;
                  all_arr_next = 1'b1;
                  state_next   = mspi_pkg::ST_TICK_RD;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      mspi_pkg::ST_FRAMES: begin
        if (div_rsp.done) begin
          frames_next = mspi_pkg::DIV_DW'(div_rsp.quotient) + mspi_pkg::DIV_DW'(1);
          slot_next   = '0;
          if (n_use == '0) begin
            move_active_next = 1'b1;
            state_next       = mspi_pkg::ST_IDLE;
          end else begin
            state_next = mspi_pkg::ST_STEP_RD;
          end
        end
      end
      mspi_pkg::ST_STEP_RD: begin
        state_next = mspi_pkg::ST_STEP_GO;
      end
      mspi_pkg::ST_STEP_GO: begin
        div_req.start = 1'b1;
        state_next    = mspi_pkg::ST_STEP_WAIT;
      end
      mspi_pkg::ST_STEP_WAIT: begin
        if (div_rsp.done) begin
          stp_we = 1'b1;
          if (last_slot) begin
            move_active_next = 1'b1;
            state_next       = mspi_pkg::ST_IDLE;
          end else begin
            slot_next  = slot + CW'(1);
            state_next = mspi_pkg::ST_STEP_RD;
          end
        end
      end
      mspi_pkg::ST_TICK_RD: begin
        state_next = mspi_pkg::ST_TICK_UPD;
      end
      mspi_pkg::ST_TICK_UPD: begin
        cur_we       = 1'b1;
        cur_wdata    = new_cur;
        all_arr_next = all_arr && arr_i;
        if (last_slot) begin
          move_active_next = !(all_arr && arr_i);
          slot_next        = '0;
          state_next       = mspi_pkg::ST_EMIT_RD;
        end else begin
          slot_next  = slot + CW'(1);
          state_next = mspi_pkg::ST_TICK_RD;
        end
      end
      mspi_pkg::ST_EMIT_RD: begin
        state_next = mspi_pkg::ST_EMIT_LOAD;
      end
      mspi_pkg::ST_EMIT_LOAD: begin
        // Hold until the output register is free.
        if (!out_valid || out_ready) begin
          ld = 1'b1;
          if (last_slot) begin
            state_next = mspi_pkg::ST_IDLE;
          end else begin
            slot_next  = slot + CW'(1);
            state_next = mspi_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = mspi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_servo_id <= id_rd;
      out_position <= cur_rd[PW-1:FRACTION_BITS];
      last         <= last_slot;
      moving       <= move_active;
    end
  end

endmodule

`default_nettype wire

// ----- sv/mspi_checker.sv -----
// Port-level checker for the pose interpolator, bound to the top level.
`default_nettype none

`include "multi_servo_pose_interpolator_assert.svh"

module mspi_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic [mspi_pkg::OP_W-1:0]  operation,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [mspi_pkg::POS_W-1:0] out_position,
  input wire logic                       last
);

  `MSPI_ASSERT(a_out_valid_hold, (out_valid && !out_ready) |=> out_valid, "out_valid dropped")
  `MSPI_ASSERT_HOLD(a_out_pos_hold, out_valid, out_ready, out_position, "stalled position moved")
  `MSPI_ASSERT(a_start_busy, (in_valid && in_ready && operation == mspi_pkg::OP_START) |=> !in_ready, "ready during start")
  `MSPI_ASSERT(a_emit_busy, (out_valid && !last) |-> !in_ready, "ready before last result")

endmodule

bind multi_servo_pose_interpolator mspi_checker u_mspi_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .operation(operation),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_position(out_position),
  .last(last)
);

`default_nettype wire
